// ===== rtl/motor_stop_rpm_controller_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Motor stop/rpm controller assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MOTOR_STOP_RPM_CONTROLLER_UNIT_DEFINES_SVH
`define MOTOR_STOP_RPM_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MSRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("msrc: assertion failed");
`define MSRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msrc: implication failed");
`else
`define MSRC_ASSERT(lbl, clk, rst_n, prop)
`define MSRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/msrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor stop/rpm controller package
// Widths, reset values, codes and shared types.
// ----------------------------------------------------------------------------
package msrc_pkg;

    localparam int TIME_WIDTH  = 32;
    localparam int TW_CNT_W    = $clog2(TIME_WIDTH);
    localparam int RPM_W       = 16;
    localparam int DIV_CNT_W   = $clog2(RPM_W);
    localparam int SPEED_W     = 8;
    localparam int TIMEOUT_W   = 16;
    localparam int TS_W        = 32;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 24;

    localparam logic [RPM_W-1:0]     RPM_NUMERATOR     = 16'd60000;
    localparam logic [SPEED_W-1:0]   MIN_RUN_SPEED_RST = 8'd60;
    localparam logic [TIMEOUT_W-1:0] STOP_TIMEOUT_RST  = 16'd5000;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_RUN_SPEED = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STOP_TIMEOUT  = 1'b1;

    localparam logic OP_SPEED = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_RUNNING  = 2'd1,
        MODE_STOPPING = 2'd2
    } t_mode;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] rot;
        logic                  rot_nz;
        logic                  timed_out;
    } t_diff_res;

endpackage

// ===== rtl/msrc_diff.sv =====
// ----------------------------------------------------------------------------
// Serial time difference unit
// Bit-serial, LSB first: rotation time, elapsed stop time and timeout compare.
// ----------------------------------------------------------------------------
module msrc_diff import msrc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [TIME_WIDTH-1:0] i_now,
    input  logic [TIME_WIDTH-1:0] i_last,
    input  logic [TIME_WIDTH-1:0] i_stop,
    input  logic [TIMEOUT_W-1:0]  i_timeout,
    output logic                  o_done,
    output t_diff_res             o_res
);

    logic                  r_busy;
    logic                  r_done;
    logic [TW_CNT_W-1:0]   r_cnt;
    logic [TIME_WIDTH-1:0] r_a;
    logic [TIME_WIDTH-1:0] r_b;
    logic [TIME_WIDTH-1:0] r_c;
    logic [TIME_WIDTH-1:0] r_t;
    logic [TIME_WIDTH-1:0] r_rot;
    logic                  r_bor_rot;
    logic                  r_bor_el;
    logic                  r_gt;
    logic                  r_nz;

    logic n_rot_bit;
    logic n_el_bit;

    assign n_rot_bit = r_a[0] ^ r_b[0] ^ r_bor_rot;
    assign n_el_bit  = r_a[0] ^ r_c[0] ^ r_bor_el;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == TW_CNT_W'(TIME_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a       <= i_now;
            r_b       <= i_last;
            r_c       <= i_stop;
            r_t       <= TIME_WIDTH'(i_timeout);
            r_bor_rot <= 1'b0;
            r_bor_el  <= 1'b0;
            r_gt      <= 1'b0;
            r_nz      <= 1'b0;
        end else if (r_busy) begin
            r_a       <= r_a >> 1;
            r_b       <= r_b >> 1;
            r_c       <= r_c >> 1;
            r_t       <= r_t >> 1;
            r_rot     <= {n_rot_bit, r_rot[TIME_WIDTH-1:1]};
            r_bor_rot <= (~r_a[0] & r_b[0]) | (~(r_a[0] ^ r_b[0]) & r_bor_rot);
            r_bor_el  <= (~r_a[0] & r_c[0]) | (~(r_a[0] ^ r_c[0]) & r_bor_el);
            r_gt      <= (n_el_bit & ~r_t[0]) | (~(n_el_bit ^ r_t[0]) & r_gt);
            r_nz      <= r_nz | n_rot_bit;
        end
    end

    assign o_done          = r_done;
    assign o_res.rot       = r_rot;
    assign o_res.rot_nz    = r_nz;
    assign o_res.timed_out = r_gt;

endmodule

// ===== rtl/msrc_div.sv =====
// ----------------------------------------------------------------------------
// Serial rpm divider
// Restoring division of the rpm numerator by the rotation time, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module msrc_div import msrc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [TIME_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [RPM_W-1:0]      o_quot
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [TIME_WIDTH:0]   r_rem;
    logic [TIME_WIDTH-1:0] r_div;
    logic [RPM_W-1:0]      r_num;
    logic [RPM_W-1:0]      r_q;

    logic [TIME_WIDTH:0] n_trial;
    logic                n_ge;

    assign n_trial = {r_rem[TIME_WIDTH-1:0], r_num[RPM_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(RPM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_num <= RPM_NUMERATOR;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_trial - {1'b0, r_div}) : n_trial;
            r_num <= {r_num[RPM_W-2:0], 1'b0};
            r_q   <= {r_q[RPM_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/motor_stop_rpm_controller_unit.sv =====
// Speed command: input registered, then written to the output register in
// write-back once the output is free. Tick: the serial difference unit
// runs, then in a measuring mode the one-bit-per-cycle divider on a falling
// edge with a nonzero rotation time. One item in flight; the next input is
// taken the cycle after the result enters the output register.
// Reset: synchronous active low, all modes and measurements cleared.
// ----------------------------------------------------------------------------
// Motor stop/rpm controller unit
// Three-mode motor controller with serial rotation time and rpm measurement.
// ----------------------------------------------------------------------------
`include "motor_stop_rpm_controller_unit_defines.svh"

module motor_stop_rpm_controller_unit import msrc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // speed_value[7:0], sensor_level[8], time_ms[40:9], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // drive_on[0], motor_stopped[1], speed_rpm[17:2], run_mode[19:18], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIFF,
        S_DIV,
        S_WB
    } t_state;

    t_state                r_state;
    logic [SPEED_W-1:0]    r_min_speed;
    logic [TIMEOUT_W-1:0]  r_timeout;
    t_mode                 r_mode;
    logic                  r_prev;
    logic [TIME_WIDTH-1:0] r_last;
    logic [TIME_WIDTH-1:0] r_stop;
    logic [RPM_W-1:0]      r_rpm;
    logic                  r_drive;
    logic                  r_op;
    logic [SPEED_W-1:0]    r_speed;
    logic                  r_sens;
    logic [TIME_WIDTH-1:0] r_now;
    logic                  r_diff_go;
    logic                  r_div_go;
    logic                  r_oval;
    logic [OUT_DATA_W-1:0] r_odata;

    t_mode                 n_mode;
    logic                  n_prev;
    logic [TIME_WIDTH-1:0] n_last;
    logic [TIME_WIDTH-1:0] n_stop;
    logic [RPM_W-1:0]      n_rpm;
    logic                  n_drive;
    logic [OUT_DATA_W-1:0] n_odata;

    logic                  diff_done;
    t_diff_res             diff_res;
    logic                  div_done;
    logic [RPM_W-1:0]      div_quot;
    logic                  falling;
    logic                  rising;
    logic                  measuring;
    logic                  out_free;

    msrc_diff u_diff (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_diff_go),
        .i_now     (r_now),
        .i_last    (r_last),
        .i_stop    (r_stop),
        .i_timeout (r_timeout),
        .o_done    (diff_done),
        .o_res     (diff_res)
    );

    msrc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_go),
        .i_divisor (diff_res.rot),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    assign falling   = ~r_sens & r_prev;
    assign rising    = r_sens & ~r_prev;
    assign measuring = (r_mode == MODE_RUNNING) || (r_mode == MODE_STOPPING);
    assign out_free  = !r_oval || m_axis_tready;

    always_comb begin
        n_mode  = r_mode;
        n_prev  = r_prev;
        n_last  = r_last;
        n_stop  = r_stop;
        n_rpm   = r_rpm;
        n_drive = r_drive;
        if (r_op == OP_SPEED) begin
            if (r_speed > r_min_speed) begin
                n_mode = MODE_RUNNING;
            end else if (r_mode == MODE_RUNNING) begin
                n_mode = MODE_STOPPING;
                n_stop = r_now;
            end
        end else begin
            if (measuring) begin
                if (falling) begin
                    n_rpm  = diff_res.rot_nz ? div_quot : RPM_NUMERATOR;
                    n_last = r_now;
                end
            end else begin
                n_rpm = '0;
            end
            unique case (r_mode)
                MODE_RUNNING: begin
                    n_drive = 1'b1;
                end
                MODE_STOPPED: begin
                    n_drive = 1'b0;
                end
                MODE_STOPPING: begin
                    if (diff_res.timed_out || rising) begin
                        n_mode  = MODE_STOPPED;
                        n_drive = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            n_prev = r_sens;
        end
        n_odata = {4'b0, n_mode, n_rpm, (n_mode == MODE_STOPPED), n_drive};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_speed <= MIN_RUN_SPEED_RST;
            r_timeout   <= STOP_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MIN_RUN_SPEED: r_min_speed <= i_cfg_wdata[SPEED_W-1:0];
                CFG_STOP_TIMEOUT:  r_timeout   <= i_cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_STOPPED;
            r_prev    <= 1'b0;
            r_last    <= '0;
            r_stop    <= '0;
            r_rpm     <= '0;
            r_drive   <= 1'b0;
            r_diff_go <= 1'b0;
            r_div_go  <= 1'b0;
            r_oval    <= 1'b0;
        end else begin
            r_diff_go <= 1'b0;
            r_div_go  <= 1'b0;
            if (m_axis_tready) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= s_axis_tuser;
                        r_speed <= s_axis_tdata[7:0];
                        r_sens  <= s_axis_tdata[8];
                        r_now   <= TIME_WIDTH'(s_axis_tdata[40:9]);
                        if (s_axis_tuser == OP_TICK) begin
                            r_diff_go <= 1'b1;
                            r_state   <= S_DIFF;
                        end else begin
                            r_state <= S_WB;
                        end
                    end
                end
                S_DIFF: begin
                    if (diff_done) begin
                        if (measuring && falling && diff_res.rot_nz) begin
                            r_div_go <= 1'b1;
                            r_state  <= S_DIV;
                        end else begin
                            r_state <= S_WB;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (out_free) begin
                        r_mode  <= n_mode;
                        r_prev  <= n_prev;
                        r_last  <= n_last;
                        r_stop  <= n_stop;
                        r_rpm   <= n_rpm;
                        r_drive <= n_drive;
                        r_odata <= n_odata;
                        r_oval  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

    `MSRC_ASSERT_IMP(a_mode_legal, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[19:18] != 2'd3)
    `MSRC_ASSERT_IMP(a_stopped_flag, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[1] == (m_axis_tdata[19:18] == MODE_STOPPED))
    `MSRC_ASSERT_IMP(a_div_mode, i_clk, i_rst_n, r_state == S_DIV, r_mode == MODE_RUNNING || r_mode == MODE_STOPPING)

endmodule
